>>> rtl/gsgp_pkg.sv
// shared types and constants of the greedy square grid partition block
package gsgp_pkg;

  // field and register widths
  localparam int unsigned DIM_W = 7;   // grid size registers and internal coordinates
  localparam int unsigned XY_W  = 6;   // coordinate fields on the ports
  localparam int unsigned CUR_W = 14;  // raster cursor, holds up to 127 * 127
  localparam int unsigned CNT_W = 13;  // squares made since clear
  localparam int unsigned IDX_W = 12;  // square index on the result

  localparam logic [DIM_W-1:0] SIZE_RESET = 7'd64;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_start;
    logic sweep;
    logic set_we;
    logic div_start;
    logic div_step;
    logic scan_adv;
    logic grow_step;
    logic fill_init;
    logic fill_step;
    logic load_found;
    logic load_none;
  } gsgp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic div_last;
    logic cur_lt_total;
    logic cell_free;
    logic ring_end;
    logic limit_last;
    logic fill_last;
    logic out_full;
  } gsgp_stat_t;

endpackage

>>> rtl/gsgp_ctrl.sv
// controller state machine of the greedy square grid partition block
module gsgp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  gsgp_pkg::gsgp_stat_t stat_i,
  output gsgp_pkg::gsgp_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DIV       = 4'd2;
  localparam logic [3:0] S_SCAN_RD   = 4'd3;
  localparam logic [3:0] S_SCAN_CHK  = 4'd4;
  localparam logic [3:0] S_GROW_RD   = 4'd5;
  localparam logic [3:0] S_GROW_CHK  = 4'd6;
  localparam logic [3:0] S_FILL_INIT = 4'd7;
  localparam logic [3:0] S_FILL      = 4'd8;
  localparam logic [3:0] S_DONE_F    = 4'd9;
  localparam logic [3:0] S_DONE_N    = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            gsgp_pkg::CMD_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLR;
            end
            gsgp_pkg::CMD_SET: begin
              cmd_o.set_we = 1'b1;
            end
            gsgp_pkg::CMD_FIND: begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (stat_i.cur_lt_total) state_d = S_SCAN_CHK;
        else state_d = S_DONE_N;
      end
      S_SCAN_CHK: begin
        if (stat_i.cell_free) begin
          state_d = S_GROW_RD;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_GROW_RD: begin
        state_d = S_GROW_CHK;
      end
      S_GROW_CHK: begin
        if (!stat_i.cell_free) begin
          state_d = S_FILL_INIT;
        end else begin
          cmd_o.grow_step = 1'b1;
          if (stat_i.ring_end && stat_i.limit_last) state_d = S_FILL_INIT;
          else state_d = S_GROW_RD;
        end
      end
      S_FILL_INIT: begin
        cmd_o.fill_init = 1'b1;
        state_d         = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) state_d = S_DONE_F;
      end
      S_DONE_F: begin
        if (!stat_i.out_full) begin
          cmd_o.load_found = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_DONE_N: begin
        if (!stat_i.out_full) begin
          cmd_o.load_none = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

endmodule

>>> rtl/gsgp_datapath.sv
// datapath of the greedy square grid partition block: cell stores, cursor, counters
module gsgp_datapath #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [6:0]           cfg_data_i,
  input  logic [5:0]           cell_x_i,
  input  logic [5:0]           cell_y_i,
  input  logic                 cell_walkable_i,
  input  gsgp_pkg::gsgp_cmd_t  cmd_i,
  output gsgp_pkg::gsgp_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [5:0]           square_x_o,
  output logic [5:0]           square_y_o,
  output logic [6:0]           square_side_o,
  output logic [11:0]          square_index_o
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned DW    = gsgp_pkg::DIM_W;
  localparam int unsigned CW    = gsgp_pkg::CUR_W;

  function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [31:0] a;
    a = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    return a[AW-1:0];
  endfunction

  // size registers
  logic [DW-1:0] width_q, height_q, used_w, used_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gsgp_pkg::SIZE_RESET;
      height_q <= gsgp_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gsgp_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        gsgp_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign used_w = (32'(width_q) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : width_q;
  assign used_h = (32'(height_q) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : height_q;

  logic [CW-1:0] total;
  assign total = CW'(used_w) * CW'(used_h);

  // scan and square state
  logic [CW-1:0]              cursor_q, cursor_d;
  logic [gsgp_pkg::CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]              sweep_q, sweep_d;
  logic [DW-1:0]              cx_q, cy_q, i_q, j_q, side_q;
  logic                       phase_q;
  logic [CW-1:0]              dvd_q;
  logic [DW-1:0]              rem_q;
  logic [3:0]                 dcnt_q;

  // restoring divide step: cursor / width gives row, remainder gives column
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [CW-1:0] dvd_next;
  assign trial    = {rem_q, dvd_q[CW-1]};
  assign ge       = trial >= {1'b0, used_w};
  assign rem_next = ge ? DW'(trial - {1'b0, used_w}) : DW'(trial);
  assign dvd_next = {dvd_q[CW-2:0], ge};

  logic [DW-1:0] limit;
  assign limit = ((used_w - cx_q) < (used_h - cy_q)) ? (used_w - cx_q) : (used_h - cy_q);

  logic [DW-1:0] side_m1;
  assign side_m1 = side_q - DW'(1);

  // walked cell address
  logic [DW-1:0] rx, ry;
  logic [AW-1:0] rd_addr;
  assign rx      = phase_q ? (cx_q + i_q) : (cx_q + j_q);
  assign ry      = phase_q ? (cy_q + j_q) : (cy_q + i_q);
  assign rd_addr = cell_addr(rx, ry);

  // cell stores
  logic walk_mem [CELLS];
  logic asg_mem  [CELLS];
  logic walk_rd_q, asg_rd_q;

  logic          set_in_grid;
  logic          walk_we, walk_wd, asg_we, asg_wd;
  logic [AW-1:0] walk_wa, asg_wa;

  assign set_in_grid = ({1'b0, cell_x_i} < used_w) && ({1'b0, cell_y_i} < used_h);

  always_comb begin
    if (cmd_i.sweep) begin
      walk_we = 1'b1;
      walk_wa = sweep_q;
      walk_wd = 1'b1;
    end else begin
      walk_we = cmd_i.set_we && set_in_grid;
      walk_wa = cell_addr({1'b0, cell_x_i}, {1'b0, cell_y_i});
      walk_wd = cell_walkable_i;
    end
    if (cmd_i.sweep) begin
      asg_we = 1'b1;
      asg_wa = sweep_q;
      asg_wd = 1'b0;
    end else begin
      asg_we = cmd_i.fill_step;
      asg_wa = rd_addr;
      asg_wd = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_rd_q <= walk_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) asg_mem[asg_wa] <= asg_wd;
    asg_rd_q <= asg_mem[rd_addr];
  end

  // control registers
  always_comb begin
    cursor_d = cursor_q;
    count_d  = count_q;
    sweep_d  = sweep_q;
    if (cmd_i.clr_start) begin
      cursor_d = '0;
      count_d  = '0;
      sweep_d  = '0;
    end
    if (cmd_i.sweep) sweep_d = sweep_q + AW'(1);
    if (cmd_i.scan_adv) cursor_d = cursor_q + CW'(1);
    if (cmd_i.load_found) count_d = count_q + gsgp_pkg::CNT_W'(1);
    if (cmd_i.load_none && (cursor_q > total)) cursor_d = total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
      sweep_q  <= '0;
    end else begin
      cursor_q <= cursor_d;
      count_q  <= count_d;
      sweep_q  <= sweep_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q   <= cursor_q;
      rem_q   <= '0;
      dcnt_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      phase_q <= 1'b0;
      side_q  <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q  <= dvd_next;
      rem_q  <= rem_next;
      dcnt_q <= dcnt_q + 4'd1;
      cx_q   <= rem_next;
      cy_q   <= DW'(dvd_next);
    end
    if (cmd_i.scan_adv) begin
      if (({1'b0, cx_q} + 8'd1) == {1'b0, used_w}) begin
        cx_q <= '0;
        cy_q <= cy_q + DW'(1);
      end else begin
        cx_q <= cx_q + DW'(1);
      end
    end
    if (cmd_i.grow_step) begin
      if (j_q == i_q) begin
        j_q     <= '0;
        phase_q <= ~phase_q;
        if (phase_q) begin
          side_q <= i_q + DW'(1);
          i_q    <= i_q + DW'(1);
        end
      end else begin
        j_q <= j_q + DW'(1);
      end
    end
    if (cmd_i.fill_init) begin
      i_q     <= '0;
      j_q     <= '0;
      phase_q <= 1'b0;
    end
    if (cmd_i.fill_step) begin
      if (j_q == side_m1) begin
        j_q <= '0;
        i_q <= i_q + DW'(1);
      end else begin
        j_q <= j_q + DW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.load_found || cmd_i.load_none) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_found) begin
      found_o        <= 1'b1;
      square_x_o     <= cx_q[5:0];
      square_y_o     <= cy_q[5:0];
      square_side_o  <= side_q;
      square_index_o <= count_q[gsgp_pkg::IDX_W-1:0];
    end else if (cmd_i.load_none) begin
      found_o        <= 1'b0;
      square_x_o     <= '0;
      square_y_o     <= '0;
      square_side_o  <= '0;
      square_index_o <= '0;
    end
  end

  assign stat_o.sweep_last   = (sweep_q == AW'(CELLS - 1));
  assign stat_o.div_last     = (dcnt_q == 4'(CW - 1));
  assign stat_o.cur_lt_total = (cursor_q < total);
  assign stat_o.cell_free    = walk_rd_q && !asg_rd_q;
  assign stat_o.ring_end     = (j_q == i_q) && phase_q;
  assign stat_o.limit_last   = (({1'b0, i_q} + 8'd1) == {1'b0, limit});
  assign stat_o.fill_last    = (j_q == side_m1) && (i_q == side_m1);
  assign stat_o.out_full     = out_valid_o && out_stall_i;

endmodule

>>> rtl/greedy_square_grid_partition.sv
// greedy square partition of an occupancy grid: top level
// set writes one cell inside the grid; clear sweeps every store entry (one store entry swept per cycle);
// find divides the cursor by the width, scans cells, checks border cells while growing,
// fills the cells of the square and then delivers the result
// one item at a time; the single read port of the cell stores paces the whole walk
// reset runs the clear sweep with the input stalled
module greedy_square_grid_partition #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // command items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_walkable_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [5:0]  square_x_o,
  output logic [5:0]  square_y_o,
  output logic [6:0]  square_side_o,
  output logic [11:0] square_index_o
);

  // command and status between controller and datapath
  gsgp_pkg::gsgp_cmd_t  cmd;
  gsgp_pkg::gsgp_stat_t stat;

  // sequencer: sweep, divide, scan, grow, fill, deliver
  gsgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // cell stores, raster cursor, square counters and result register
  gsgp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_walkable_i (cell_walkable_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .square_x_o      (square_x_o),
    .square_y_o      (square_y_o),
    .square_side_o   (square_side_o),
    .square_index_o  (square_index_o)
  );

  // a not-found item carries all zero fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> square_side_o == 7'd0 && square_index_o == 12'd0)
    else $error("not-found item with nonzero fields");

  // a found square is never empty
  a_found_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> square_side_o != 7'd0)
    else $error("found square with zero side");

  // a result is only loaded while the controller is busy with a find
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_found || cmd.load_none) |-> in_stall_o)
    else $error("result loaded outside a find");

endmodule

>>> bench/tb_greedy_square_grid_partition.sv
// testbench of the greedy square grid partition block: directed table, then random phases
module tb_greedy_square_grid_partition;
  timeunit 1ns;
  timeprecision 1ps;

  // command codes of the block
  localparam logic [1:0] CMD_CLEAR = gsgp_pkg::CMD_CLEAR;
  localparam logic [1:0] CMD_SET   = gsgp_pkg::CMD_SET;
  localparam logic [1:0] CMD_FIND  = gsgp_pkg::CMD_FIND;
  // unused command code, the block must ignore it
  localparam logic [1:0] CMD_NONE = 2'd3;
  // longest item with no result is a clear sweep of the whole store
  localparam int unsigned SWEEP_WAIT = 64 * 64 + 200;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 12;

  typedef struct packed {
    logic       found;
    logic [5:0] x;
    logic [5:0] y;
    logic [6:0] side;
    logic [11:0] idx;
  } square_t;

  // one row of the directed table: either a register write pair or an item
  typedef struct packed {
    logic       is_cfg;
    logic [6:0] cw;
    logic [6:0] ch;
    logic [1:0] cmd;
    logic [5:0] x;
    logic [5:0] y;
    logic       wk;
    logic       typed;
    square_t    want;
  } row_t;

  localparam square_t NONE = '{1'b0, 6'd0, 6'd0, 7'd0, 12'd0};
  localparam int unsigned NROWS = 27;
  localparam row_t DIRECTED [NROWS] = '{
    // full 64x64 empty grid after reset: one square covers everything
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b1, 6'd0, 6'd0, 7'd64, 12'd0}},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_NONE, 6'd63, 6'd63, 1'b1, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    // oversized sizes saturate, a zero height or a zero width is an empty grid
    '{1'b1, 7'd127, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, NONE},
    '{1'b1, 7'd0, 7'd127, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, NONE},
    // small 5x3 grid with blocked cells and a set outside the grid
    '{1'b1, 7'd5, 7'd3, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_SET, 6'd4, 6'd2, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_SET, 6'd63, 6'd63, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_SET, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    // cell behind the cursor made walkable again is not revisited
    '{1'b0, 7'd0, 7'd0, CMD_SET, 6'd0, 6'd0, 1'b1, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b1, 6'd0, 6'd0, 7'd3, 12'd0}},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    // single cell grid
    '{1'b1, 7'd1, 7'd1, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, '{1'b1, 6'd0, 6'd0, 7'd1, 12'd0}},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b1, NONE},
    // widen again: cursor keeps its raster position under the new width
    '{1'b1, 7'd64, 7'd64, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE},
    '{1'b0, 7'd0, 7'd0, CMD_FIND, 6'd0, 6'd0, 1'b0, 1'b0, NONE}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [5:0]  cell_x_i;
  logic [5:0]  cell_y_i;
  logic        cell_walkable_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic [5:0]  square_x_o;
  logic [5:0]  square_y_o;
  logic [6:0]  square_side_o;
  logic [11:0] square_index_o;

  greedy_square_grid_partition u_top (.*);

  // predictor state: cells kept at fixed places [y][x]
  bit          walk_map [64][64];
  bit          taken_map [64][64];
  int unsigned scan_pos;
  int unsigned made_count;
  int unsigned width_reg;
  int unsigned height_reg;

  square_t     pending_squares [$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          hold_req;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic void wipe_grid();
    foreach (walk_map[y, x]) begin
      walk_map[y][x] = 1'b1;
      taken_map[y][x] = 1'b0;
    end
    scan_pos = 0;
    made_count = 0;
  endfunction

  function automatic bit cell_open(int unsigned x, int unsigned y);
    return walk_map[y][x] && !taken_map[y][x];
  endfunction

  // largest free square anchored at (x, y), growing one border ring at a time
  function automatic int unsigned grow_side(int unsigned x, int unsigned y,
                                            int unsigned w, int unsigned h);
    int unsigned lim;
    int unsigned side;
    bit ok;
    lim = ((w - x) < (h - y)) ? (w - x) : (h - y);
    side = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      ok = 1'b1;
      for (int unsigned j = 0; j <= i; j++)
        if (!cell_open(x + j, y + i) || !cell_open(x + i, y + j)) ok = 1'b0;
      if (!ok) break;
      side++;
    end
    return side;
  endfunction

  // advance the grid state by one item; a find pushes its square
  function automatic void partition_step(logic [1:0] cmd, logic [5:0] x, logic [5:0] y,
                                         logic wk);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned cx;
    int unsigned cy;
    int unsigned side;
    square_t sq;
    w = (width_reg > 64) ? 64 : width_reg;
    h = (height_reg > 64) ? 64 : height_reg;
    case (cmd)
      CMD_CLEAR: wipe_grid();
      CMD_SET: if (x < w && y < h) walk_map[y][x] = wk;
      CMD_FIND: begin
        sq = NONE;
        total = w * h;
        while (scan_pos < total) begin
          cx = scan_pos % w;
          cy = scan_pos / w;
          if (cell_open(cx, cy)) begin
            side = grow_side(cx, cy, w, h);
            for (int unsigned b = 0; b < side; b++)
              for (int unsigned a = 0; a < side; a++) taken_map[cy + b][cx + a] = 1'b1;
            sq = '{1'b1, cx[5:0], cy[5:0], side[6:0], made_count[11:0]};
            made_count = (made_count + 1) & 32'h1fff;
            break;
          end
          scan_pos++;
        end
        if (scan_pos > total) scan_pos = total;
        pending_squares.push_back(sq);
      end
      default: ;
    endcase
  endfunction

  // offer one item, honoring the burst and gap pattern, until it is taken
  task automatic offer_item(logic [1:0] cmd, logic [5:0] x, logic [5:0] y, logic wk);
    int unsigned gap;
    bit stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    cell_x_i        <= x;
    cell_y_i        <= y;
    cell_walkable_i <= wk;
    // stall is looked at mid-cycle, so it is the value seen at the coming edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // drain, let any clear sweep finish, then write both size registers
  task automatic set_grid_size(logic [6:0] w, logic [6:0] h);
    in_valid_i <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk_i);
    repeat (SWEEP_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gsgp_pkg::REG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= gsgp_pkg::REG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg  = 32'(w);
    height_reg = 32'(h);
    burst_left = 0;
  endtask

  // result checker: oldest expectation against each accepted result item
  always @(posedge clk_i) begin
    square_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_squares.size() == 0) begin
        $display("%0t: unexpected result item found=%0b x=%0d y=%0d side=%0d index=%0d",
                 $time, found_o, square_x_o, square_y_o, square_side_o, square_index_o);
        errors++;
      end else begin
        want = pending_squares.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found expected %0b got %0b", $time, want.found, found_o);
          errors++;
        end
        if (square_x_o !== want.x) begin
          $display("%0t: square_x expected %0d got %0d", $time, want.x, square_x_o);
          errors++;
        end
        if (square_y_o !== want.y) begin
          $display("%0t: square_y expected %0d got %0d", $time, want.y, square_y_o);
          errors++;
        end
        if (square_side_o !== want.side) begin
          $display("%0t: square_side expected %0d got %0d", $time, want.side, square_side_o);
          errors++;
        end
        if (square_index_o !== want.idx) begin
          $display("%0t: square_index expected %0d got %0d", $time, want.idx, square_index_o);
          errors++;
        end
      end
    end
  end

  // receiver: stall patterns of random length, plus one long hold on request
  initial begin
    int unsigned mode;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk_i);
        if (hold_req) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // watchdog: too long without any item accepted on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    logic [5:0] rx;
    logic [5:0] ry;
    row_t r;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = gsgp_pkg::REG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_CLEAR;
    cell_x_i = '0;
    cell_y_i = '0;
    cell_walkable_i = 1'b0;
    width_reg = 32'(gsgp_pkg::SIZE_RESET);
    height_reg = 32'(gsgp_pkg::SIZE_RESET);
    wipe_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; typed rows replace the predicted square
    for (int i = 0; i < NROWS; i++) begin
      r = DIRECTED[i];
      if (r.is_cfg) set_grid_size(r.cw, r.ch);
      else begin
        offer_item(r.cmd, r.x, r.y, r.wk);
        partition_step(r.cmd, r.x, r.y, r.wk);
        if (r.typed) begin
          void'(pending_squares.pop_back());
          pending_squares.push_back(r.want);
        end
      end
    end

    // random phases: new size, usually a fresh grid, then sets, finds, unused codes and clears
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin w = 64; h = 64; end
        1: begin w = 127; h = 127; end
        2: begin w = 0; h = $urandom_range(1, 8); end
        3: begin w = $urandom_range(1, 8); h = 0; end
        4: begin w = 1; h = $urandom_range(1, 8); end
        default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10); end
      endcase
      set_grid_size(w[6:0], h[6:0]);
      if (w > 64) w = 64;
      if (h > 64) h = 64;
      // one long receiver hold while the sender keeps offering
      if (p == 5) hold_req = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        offer_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
        partition_step(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        rx = 6'($urandom);
        ry = 6'($urandom);
        if (pick < 45) begin
          // mostly cells inside the grid, some anywhere
          if (w != 0 && h != 0 && $urandom_range(0, 2) != 0) begin
            rx = 6'($urandom_range(0, w - 1));
            ry = 6'($urandom_range(0, h - 1));
          end
          offer_item(CMD_SET, rx, ry, ($urandom_range(0, 2) != 0) ? 1'b0 : 1'b1);
          partition_step(CMD_SET, cell_x_i, cell_y_i, cell_walkable_i);
        end else if (pick < 90) begin
          offer_item(CMD_FIND, rx, ry, 1'($urandom));
          partition_step(CMD_FIND, rx, ry, 1'b0);
        end else if (pick < 95) begin
          offer_item(CMD_NONE, rx, ry, 1'($urandom));
          partition_step(CMD_NONE, rx, ry, 1'b0);
        end else begin
          offer_item(CMD_CLEAR, rx, ry, 1'($urandom));
          partition_step(CMD_CLEAR, rx, ry, 1'b0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk_i);
    repeat (SWEEP_WAIT) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/gsgp_pkg.sv
rtl/gsgp_ctrl.sv
rtl/gsgp_datapath.sv
rtl/greedy_square_grid_partition.sv
bench/tb_greedy_square_grid_partition.sv
